[rtl/core/sfr_pkg.sv]
// sfr_pkg: shared constants, types and codes for the stream find-and-replace unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package sfr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  // One cell per byte of the working buffer: held bytes plus the new byte
  localparam int CELLS       = PATTERN_MAX;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;   // capture the incoming text byte
    logic shift;  // take the right neighbor's byte
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage
`default_nettype wire

[rtl/core/sfr_cell.sv]
// sfr_cell: one byte cell of the buffer chain; holds a byte, shifts left, and
// compares its byte against every pattern byte. Depends on sfr_pkg.
`default_nettype none
module sfr_cell
  import sfr_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic [7:0]              load_byte,
  input  wire logic [7:0]              right_byte,
  input  wire logic [8*PATTERN_MAX-1:0] pattern,
  output logic [7:0]                   cell_byte,
  output logic [PATTERN_MAX-1:0]       eq
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = right_byte;
    end else if (ctl.load) begin
      byte_nxt = load_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = (byte_r == pattern[i*8 +: 8]);
    end
  end

  assign cell_byte = byte_r;

endmodule
`default_nettype wire

[rtl/core/sfr_match.sv]
// sfr_match: picks the longest buffer suffix that equals a pattern prefix,
// from the per-cell compare results. Depends on sfr_pkg.
`default_nettype none
module sfr_match
  import sfr_pkg::*;
(
  input  wire logic [CELLS-1:0][PATTERN_MAX-1:0] eq,
  input  wire logic [3:0]                        fill,
  input  wire logic [3:0]                        plen,
  output logic [3:0]                             best
);

  always_comb begin
    logic       ok;
    logic [3:0] pos;
    best = 4'd0;
    for (int k = 1; k <= PATTERN_MAX; k++) begin
      ok = (4'(k) <= fill) && (4'(k) <= plen);
      for (int i = 0; i < k; i++) begin
        pos = fill - 4'(k) + 4'(i);
        ok  = ok && eq[pos[2:0]][i];
      end
      if (ok) begin
        best = 4'(k);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/stream_find_and_replace_unit.sv]
// stream_find_and_replace_unit: top level; sequencer, configuration registers,
// output register and the row of sfr_cell byte cells. Depends on sfr_pkg,
// sfr_cell and sfr_match.
//
// Usage:
//   in_*  : one text byte per transaction in in_tdata, in_tlast on the final byte.
//   out_* : one rewritten byte per transaction in out_tdata[7:0]; out_tdata[8]
//           flags a byte-less end marker; out_tlast marks the last item of a text.
//   cfg_* : write pattern/replacement bytes and lengths while the block is idle.
// Flow: an accepted byte is loaded into a byte cell, matched against the
//   byte cells, then its result items are emitted in turn; an item has N
//   results (N up to 15; N = 0 for a byte that stays held).
//   The emission loop runs through the single output register.
//   Input is taken again as soon as the last result is in the output register,
//   even while that result still waits for the receiver.
// Reset: rst_n low clears the held count, the sequencer and the output valid;
//   the configuration returns to an empty pattern (pass-through).
// Stall: when out_tready is low the output register holds and the sequencer
//   waits in its emit state; nothing is dropped.
`default_nettype none
module stream_find_and_replace_unit
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] text_byte
  input  wire logic              in_tlast,   // text_end
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // [7:0] out_byte, [8] out_empty, zero pad
  output logic                   out_tlast,  // out_end
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers
  logic [63:0] pattern_r;
  logic [3:0]  plen_raw_r;
  logic [63:0] replace_r;
  logic [3:0]  rlen_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      plen_raw_r <= '0;
      replace_r  <= '0;
      rlen_raw_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATTERN_BYTES:      pattern_r  <= cfg_wdata[63:0];
        REG_PATTERN_LENGTH:     plen_raw_r <= cfg_wdata[3:0];
        REG_REPLACEMENT_BYTES:  replace_r  <= cfg_wdata[63:0];
        REG_REPLACEMENT_LENGTH: rlen_raw_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Saturate oversized lengths
  logic [3:0] plen;
  logic [3:0] rlen;
  assign plen = (plen_raw_r > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : plen_raw_r;
  assign rlen = (rlen_raw_r > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX) : rlen_raw_r;

  // Sequencer state
  state_t     state_r, state_nxt;
  logic [2:0] held_r, held_nxt;        // bytes held in cells 0..held-1
  logic [3:0] fill_r, fill_nxt;        // buffer fill during match
  logic       end_r, end_nxt;          // current item closes the text
  logic [3:0] shift_left_r, shift_left_nxt;
  logic [3:0] repl_left_r, repl_left_nxt;
  logic [2:0] repl_idx_r, repl_idx_nxt;

  // Output register
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       oempty_r, oempty_nxt;
  logic       olast_r, olast_nxt;

  // Cell row
  cell_ctl_t                         ctl [CELLS];
  logic [CELLS-1:0][7:0]             cell_bytes;
  logic [CELLS-1:0][PATTERN_MAX-1:0] eq;
  logic [3:0]                        best;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [7:0] right_byte;
    if (j == CELLS - 1) begin : g_tail
      assign right_byte = 8'h00;
    end else begin : g_mid
      assign right_byte = cell_bytes[j+1];
    end
    sfr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[j]),
      .load_byte  (in_tdata),
      .right_byte (right_byte),
      .pattern    (pattern_r),
      .cell_byte  (cell_bytes[j]),
      .eq         (eq[j])
    );
  end

  sfr_match u_match (
    .eq   (eq),
    .fill (fill_r),
    .plen (plen),
    .best (best)
  );

  logic in_fire;
  logic out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  // Match-cycle decisions
  logic       full_match;
  logic [3:0] kept;
  logic [3:0] emit_front;
  logic [3:0] flush_cnt;
  assign full_match = (plen != 4'd0) && (best == plen);
  assign kept       = full_match ? 4'd0 : best;
  assign emit_front = fill_r - best;
  assign flush_cnt  = end_r ? kept : 4'd0;

  logic [4:0] remaining;
  assign remaining = {1'b0, shift_left_r} + {1'b0, repl_left_r};

  logic do_shift;

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    fill_nxt       = fill_r;
    end_nxt        = end_r;
    shift_left_nxt = shift_left_r;
    repl_left_nxt  = repl_left_r;
    repl_idx_nxt   = repl_idx_r;
    ovalid_nxt     = ovalid_r && !out_tready;
    obyte_nxt      = obyte_r;
    oempty_nxt     = oempty_r;
    olast_nxt      = olast_r;
    do_shift       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          fill_nxt  = {1'b0, held_r} + 4'd1;
          end_nxt   = in_tlast;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        shift_left_nxt = emit_front + flush_cnt;
        repl_left_nxt  = full_match ? rlen : 4'd0;
        repl_idx_nxt   = 3'd0;
        held_nxt       = end_r ? 3'd0 : kept[2:0];
        // Nothing to emit and text continues: all bytes stay held
        if (!end_r && (emit_front + flush_cnt == 4'd0) && !full_match) begin
          state_nxt = ST_IDLE;
        end else if (!end_r && (emit_front + flush_cnt == 4'd0) && (rlen == 4'd0)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oempty_nxt = 1'b0;
          olast_nxt  = end_r && (remaining <= 5'd1);
          if (shift_left_r != 4'd0) begin
            // Drain the front cell and advance the chain
            obyte_nxt      = cell_bytes[0];
            do_shift       = 1'b1;
            shift_left_nxt = shift_left_r - 4'd1;
          end else if (repl_left_r != 4'd0) begin
            obyte_nxt     = replace_r[repl_idx_r*8 +: 8];
            repl_idx_nxt  = repl_idx_r + 3'd1;
            repl_left_nxt = repl_left_r - 4'd1;
          end else begin
            // End of text with nothing to carry it: byte-less end marker
            obyte_nxt  = 8'h00;
            oempty_nxt = 1'b1;
          end
          if (remaining <= 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < CELLS; j++) begin
      ctl[j].shift = do_shift;
      ctl[j].load  = in_fire && (held_r == 3'(j));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r       <= fill_nxt;
    end_r        <= end_nxt;
    shift_left_r <= shift_left_nxt;
    repl_left_r  <= repl_left_nxt;
    repl_idx_r   <= repl_idx_nxt;
    obyte_r      <= obyte_nxt;
    oempty_r     <= oempty_nxt;
    olast_r      <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, oempty_r, obyte_r};
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire
